// ----- rtl/core/swa_pkg.sv -----
// Shared types and constants for the sliding window average unit.
// No dependencies; imported by every module under rtl/core.
`default_nettype none

package swa_pkg;

   // Fixed field widths of the request and response channels
   localparam int SAMPLE_W = 12;
   localparam int AVG_W    = 12;
   localparam int COUNT_W  = 5;

   // Defaults for the top-level parameters
   localparam int DEF_WINDOW_DEPTH = 16;
   localparam int DEF_SAMPLE_BITS  = 12;

   // Entries in the queue between front and back end
   localparam int QUEUE_DEPTH = 2;

   // Command codes
   localparam logic CMD_ADD   = 1'b0;
   localparam logic CMD_CLEAR = 1'b1;

   typedef struct packed {
      logic                command;
      logic [SAMPLE_W-1:0] sample;
   } req_type;

   typedef struct packed {
      logic [AVG_W-1:0]   average;
      logic [COUNT_W-1:0] sample_count;
      logic               window_full;
   } rsp_type;

   // Queue status seen by the front and back end
   typedef struct packed {
      logic valid;
      logic full;
   } qstat_type;

endpackage

`default_nettype wire

// ----- rtl/core/swa_front.sv -----
// Front end: takes requests, classifies add/clear, trims the sample.
// Depends on swa_pkg; feeds swa_queue.
`default_nettype none

module swa_front
   import swa_pkg::*;
#(
   parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   input  wire qstat_type            q_stat,
   output logic                      q_push,
   output logic [SAMPLE_BITS:0]      q_entry
);

   logic                   hold_valid_ff, hold_valid_in;
   logic [SAMPLE_BITS:0]   hold_entry_ff;
   logic [SAMPLE_BITS-1:0] smp;
   logic                   accept;

   // sample bits above SAMPLE_BITS are dropped; a narrower sample is zero-extended
   generate
      if (SAMPLE_BITS <= SAMPLE_W) begin : g_trim
         assign smp = req_data.sample[SAMPLE_BITS-1:0];
      end else begin : g_ext
         assign smp = {{(SAMPLE_BITS-SAMPLE_W){1'b0}}, req_data.sample};
      end
   endgenerate

   assign req_stall = hold_valid_ff && q_stat.full;
   assign accept    = req_valid && !req_stall;
   assign q_push    = hold_valid_ff && !q_stat.full;
   assign q_entry   = hold_entry_ff;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   // top bit flags a clear; sample is don't-care then
   always_ff @(posedge clock) begin
      if (accept) begin
         hold_entry_ff <= {(req_data.command == CMD_CLEAR), smp};
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/swa_queue.sv -----
// Short FIFO decoupling the front end from the back end.
// Depends on swa_pkg for QUEUE_DEPTH and the status struct.
`default_nettype none

module swa_queue
   import swa_pkg::*;
#(
   parameter int DATA_W = DEF_SAMPLE_BITS + 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] push_data,
   input  wire logic              pop,
   output qstat_type              stat,
   output logic [DATA_W-1:0]      pop_data
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_W-1:0] slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              do_push, do_pop;

   assign stat.valid = (count_ff != '0);
   assign stat.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push && !stat.full;
   assign do_pop     = pop && stat.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/swa_back.sv -----
// Back end: ring buffer, running sum, fill count and a bit-serial divider.
// Depends on swa_pkg; pops entries from swa_queue, drives the response port.
`default_nettype none

module swa_back
   import swa_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire qstat_type          q_stat,
   input  wire logic [SAMPLE_BITS:0] q_entry,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data
);

   localparam int SUM_W  = SAMPLE_BITS + $clog2(WINDOW_DEPTH);
   localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
   localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int STEP_W = $clog2(SUM_W + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_UPDATE = 2'd1;
   localparam logic [1:0] ST_DIV    = 2'd2;
   localparam logic [1:0] ST_DONE   = 2'd3;

   logic [SAMPLE_BITS-1:0] ring_mem [WINDOW_DEPTH];

   logic [1:0]             st_ff, st_in;
   logic [SUM_W-1:0]       sum_ff, sum_in;
   logic [PTR_W-1:0]       wp_ff, wp_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   full_ff, full_in;
   logic [SAMPLE_BITS-1:0] smp_ff, smp_in;
   logic [SAMPLE_BITS-1:0] rd_ff;
   logic [SUM_W-1:0]       quot_ff, quot_in;
   logic [CNT_W-1:0]       rem_ff, rem_in;
   logic [CNT_W-1:0]       div_ff, div_in;
   logic [STEP_W-1:0]      step_ff, step_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_ff, rsp_in;

   logic                   ring_we;
   logic [SUM_W-1:0]       old_ext, new_ext, new_sum;
   logic [CNT_W-1:0]       cnt_inc;
   logic [CNT_W:0]         rem_sh, rem_diff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign old_ext  = full_ff ? SUM_W'(rd_ff) : '0;
   assign new_ext  = SUM_W'(smp_ff);
   assign new_sum  = sum_ff - old_ext + new_ext;
   assign cnt_inc  = cnt_ff + 1'b1;

   // one restoring step: shift in next dividend bit, subtract if it fits
   assign rem_sh   = {rem_ff, quot_ff[SUM_W-1]};
   assign rem_diff = rem_sh - {1'b0, div_ff};

   always_comb begin
      st_in        = st_ff;
      sum_in       = sum_ff;
      wp_in        = wp_ff;
      cnt_in       = cnt_ff;
      full_in      = full_ff;
      smp_in       = smp_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      div_in       = div_ff;
      step_in      = step_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      q_pop        = 1'b0;
      ring_we      = 1'b0;
      case (st_ff)
         ST_IDLE: begin
            if (q_stat.valid) begin
               q_pop = 1'b1;
               if (q_entry[SAMPLE_BITS]) begin
                  sum_in  = '0;
                  wp_in   = '0;
                  cnt_in  = '0;
                  full_in = 1'b0;
                  quot_in = '0;
                  st_in   = ST_DONE;
               end else begin
                  smp_in = q_entry[SAMPLE_BITS-1:0];
                  st_in  = ST_UPDATE;
               end
            end
         end
         ST_UPDATE: begin
            ring_we = 1'b1;
            sum_in  = new_sum;
            wp_in   = (wp_ff == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
            if (!full_ff) begin
               if (cnt_inc >= CNT_W'(WINDOW_DEPTH)) begin
                  cnt_in  = CNT_W'(WINDOW_DEPTH);
                  full_in = 1'b1;
               end else begin
                  cnt_in = cnt_inc;
               end
            end
            quot_in = new_sum;
            rem_in  = '0;
            div_in  = full_ff ? cnt_ff : cnt_inc;
            step_in = STEP_W'(SUM_W);
            st_in   = ST_DIV;
         end
         ST_DIV: begin
            if (!rem_diff[CNT_W]) begin
               rem_in  = rem_diff[CNT_W-1:0];
               quot_in = SUM_W'({quot_ff, 1'b1});
            end else begin
               rem_in  = rem_sh[CNT_W-1:0];
               quot_in = SUM_W'({quot_ff, 1'b0});
            end
            step_in = step_ff - 1'b1;
            if (step_ff == STEP_W'(1)) begin
               st_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_in.average      = AVG_W'(quot_ff);
               rsp_in.sample_count = COUNT_W'(cnt_ff);
               rsp_in.window_full  = full_ff;
               rsp_valid_in        = 1'b1;
               st_in               = ST_IDLE;
            end
         end
         default: begin
            st_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_IDLE;
         sum_ff       <= '0;
         wp_ff        <= '0;
         cnt_ff       <= '0;
         full_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         sum_ff       <= sum_in;
         wp_ff        <= wp_in;
         cnt_ff       <= cnt_in;
         full_ff      <= full_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      smp_ff  <= smp_in;
      quot_ff <= quot_in;
      rem_ff  <= rem_in;
      div_ff  <= div_in;
      step_ff <= step_in;
      rsp_ff  <= rsp_in;
   end

   // ring: one write port, registered read at the write pointer
   always_ff @(posedge clock) begin
      if (ring_we) begin
         ring_mem[wp_ff] <= smp_ff;
      end
      rd_ff <= ring_mem[wp_ff];
   end

endmodule

`default_nettype wire

// ----- rtl/core/sliding_window_average_unit.sv -----
// Sliding window (boxcar) average. An add pops, updates the ring and sum, then
// divides the SUM_W-bit sum (SUM_W = SAMPLE_BITS + clog2(WINDOW_DEPTH), 16 at
// defaults) one quotient bit per cycle; a clear skips both. The response register
// takes the result once free, and the back end pops no new request until then.
// Synchronous active-high reset empties the window; the ring is not cleared and
// needs no clearing pass, as it is read only once every entry is written.
`default_nettype none

module sliding_window_average_unit
   import swa_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   // Front end: a single holding register for one request, add/clear flag in the top
   // bit of the queue entry, sample trimmed to SAMPLE_BITS.
   qstat_type              q_stat;
   logic                   q_push;
   logic                   q_pop;
   logic [SAMPLE_BITS:0]   q_push_data;
   logic [SAMPLE_BITS:0]   q_pop_data;

   swa_front #(
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_stat    (q_stat),
      .q_push    (q_push),
      .q_entry   (q_push_data)
   );

   // Short queue: lets the front keep taking requests while the divider runs
   swa_queue #(
      .DATA_W (SAMPLE_BITS + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .stat      (q_stat),
      .pop_data  (q_pop_data)
   );

   // Back end: ring update, running sum, fill count, divide, response register.
   // The response register lets the next request start while one waits.
   swa_back #(
      .WINDOW_DEPTH (WINDOW_DEPTH),
      .SAMPLE_BITS  (SAMPLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_stat    (q_stat),
      .q_entry   (q_pop_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // A full window always reports the saturated count
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.window_full |->
         rsp_data.sample_count == COUNT_W'(WINDOW_DEPTH))
      else $error("full window with wrong sample count");

   // An empty window reports a zero average
   a_empty_avg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.window_full && rsp_data.sample_count == '0 |->
         rsp_data.average == '0)
      else $error("empty window with nonzero average");

   // The back end never pops an empty queue
   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_stat.valid)
      else $error("pop from empty queue");

endmodule

`default_nettype wire

// ----- tb/sv/sliding_window_average_checker.sv -----
// Checker for the sliding window average unit: watches both channels, predicts
// each response from its own window model and compares field by field.
// Depends on swa_pkg for the request and response types.
module sliding_window_average_checker
   import swa_pkg::*;
#(
   parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
   parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_stall,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_stall,
   input  rsp_type rsp_data,
   output int      mismatch_count,
   output int      awaited_count
);

   localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_DEPTH) + 1;
   localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

   // Window model
   logic [SAMPLE_W-1:0] held_samples [WINDOW_DEPTH];
   logic [SUM_W-1:0]    window_sum;
   int                  write_slot;
   int                  fill_level;
   logic                window_is_full;

   rsp_type awaited_results [$];

   // Applies one request to the window and returns the response it must give.
   function automatic rsp_type absorb_request(input req_type r);
      rsp_type             res;
      logic [SAMPLE_W-1:0] s;
      res = '0;
      if (r.command == CMD_CLEAR) begin
         window_sum     = '0;
         write_slot     = 0;
         fill_level     = 0;
         window_is_full = 1'b0;
      end else begin
         s = r.sample & SAMPLE_MASK;
         // oldest sample drops out only once the ring has wrapped
         if (window_is_full)
            window_sum = window_sum - SUM_W'(held_samples[write_slot]);
         held_samples[write_slot] = s;
         window_sum = window_sum + SUM_W'(s);
         write_slot = (write_slot + 1 >= WINDOW_DEPTH) ? 0 : write_slot + 1;
         if (!window_is_full) begin
            fill_level = fill_level + 1;
            if (fill_level >= WINDOW_DEPTH) begin
               fill_level     = WINDOW_DEPTH;
               window_is_full = 1'b1;
            end
         end
         if (fill_level != 0)
            res.average = AVG_W'(window_sum / SUM_W'(fill_level));
      end
      res.sample_count = COUNT_W'(fill_level);
      res.window_full  = window_is_full;
      return res;
   endfunction

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (reset) begin
         window_sum     = '0;
         write_slot     = 0;
         fill_level     = 0;
         window_is_full = 1'b0;
         mismatch_count = 0;
         awaited_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_results.size() == 0) begin
               $error("unexpected response: average %0d, sample_count %0d, window_full %0d",
                      rsp_data.average, rsp_data.sample_count, rsp_data.window_full);
               mismatch_count++;
            end else begin
               want = awaited_results.pop_front();
               if (rsp_data.average !== want.average) begin
                  $error("average: expected %0d, actual %0d", want.average, rsp_data.average);
                  mismatch_count++;
               end
               if (rsp_data.sample_count !== want.sample_count) begin
                  $error("sample_count: expected %0d, actual %0d",
                         want.sample_count, rsp_data.sample_count);
                  mismatch_count++;
               end
               if (rsp_data.window_full !== want.window_full) begin
                  $error("window_full: expected %0d, actual %0d",
                         want.window_full, rsp_data.window_full);
                  mismatch_count++;
               end
            end
         end
         if (req_valid && !req_stall)
            awaited_results.push_back(absorb_request(req_data));
      end
      awaited_count <= awaited_results.size();
   end

endmodule

// ----- tb/sv/sliding_window_average_unit_tb.sv -----
// Top of the sliding window average testbench: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on swa_pkg, the unit itself
// and sliding_window_average_checker.
module sliding_window_average_unit_tb;
   import swa_pkg::*;

   localparam int RANDOM_ITEMS   = 1625;
   localparam int QUIET_ITEMS    = 150;   // tail of the run with no idling at all
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no handshake on either side
   localparam int SETTLE_CYCLES  = 64;    // longer than an add request's round trip

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic quiet_tail = 1'b0;  // set for the final stretch: both sides run flat out
   int   mismatch_count;
   int   awaited_count;
   int   idle_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   sliding_window_average_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   sliding_window_average_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .awaited_count  (awaited_count)
   );

   // Presents one request and holds it until the unit takes it. Valid is left
   // high on return so back-to-back requests need no extra assignment.
   task automatic send_request(input logic cmd, input logic [SAMPLE_W-1:0] value);
      req_valid <= 1'b1;
      req_data  <= '{command: cmd, sample: value};
      do @(posedge clock); while (!(req_valid && !req_stall));
   endtask

   task automatic pause_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Sender holds off until every outstanding response has come back.
   task automatic drain_window;
      pause_sender(1);
      while (awaited_count != 0) @(posedge clock);
   endtask

   // Sample values weighted towards the rails and near-rail values,
   // which stress the running sum and the divider.
   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return SAMPLE_W'($urandom_range(0, 15));
         3:       return SAMPLE_W'(4095 - $urandom_range(0, 15));
         default: return SAMPLE_W'($urandom);
      endcase
   endfunction

   // Response back-pressure: bursts of stall or free-running, now and then a long
   // open stretch; nothing once the quiet tail starts.
   initial begin : rsp_pressure
      int   burst;
      logic hold;
      @(posedge clock);
      forever begin
         if (quiet_tail) begin
            burst = 1;
            hold  = 1'b0;
         end else if ($urandom_range(0, 9) == 0) begin
            burst = $urandom_range(40, 120);
            hold  = 1'b0;
         end else begin
            burst = $urandom_range(1, 16);
            hold  = ($urandom_range(0, 2) == 0);
         end
         rsp_stall <= hold;
         repeat (burst) @(posedge clock);
      end
   end

   // Watchdog: a hung handshake on either side ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin : stimulus
      logic bursty;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: clear on an empty window (sample must be ignored), single
      // adds at both rails, then a full window of full-scale samples so the
      // sum peaks, then the first wrap where the oldest sample drops out.
      send_request(CMD_CLEAR, '1);
      send_request(CMD_ADD, '0);
      send_request(CMD_ADD, '1);
      send_request(CMD_CLEAR, '0);
      repeat (16) send_request(CMD_ADD, '1);
      send_request(CMD_ADD, '0);
      send_request(CMD_ADD, SAMPLE_W'(1));
      send_request(CMD_CLEAR, '1);
      drain_window();

      // Random: mostly adds so the window fills and wraps many times over,
      // with the odd clear mid-window.
      bursty = 1'b1;
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == RANDOM_ITEMS - QUIET_ITEMS)
            quiet_tail <= 1'b1;
         if (i % 64 == 0)
            bursty = ($urandom_range(0, 2) != 0);
         if (i % 400 == 200)
            drain_window();
         if (i < RANDOM_ITEMS - QUIET_ITEMS && bursty && $urandom_range(0, 3) == 0)
            pause_sender($urandom_range(1, 16));
         if ($urandom_range(0, 47) == 0)
            send_request(CMD_CLEAR, SAMPLE_W'($urandom));
         else
            send_request(CMD_ADD, pick_sample());
      end

      // Wind down: collect everything, then watch for stray responses.
      req_valid <= 1'b0;
      while (awaited_count != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
